### rtl/hba_pkg.sv
package hba_pkg;

  localparam int MAX_BINS_DEF = 1024;
  localparam int IDX_W = 10;
  localparam int CNT_W = 32;

  localparam logic [1:0] REG_LOG_MODE = 2'd0;
  localparam logic [1:0] REG_RANGE_LOW = 2'd1;
  localparam logic [1:0] REG_BIN_WIDTH = 2'd2;
  localparam logic [1:0] REG_BINS_IN_USE = 2'd3;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic        log_mode;
    logic [31:0] range_low;
    logic [30:0] bin_width;
    logic [10:0] bins_in_use;
  } cfg_t;

endpackage

### rtl/hba_log2.sv
module hba_log2 (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] x,
  output logic        done,
  output logic [21:0] result
);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_NORM = 4'b0010,
    L_SQR  = 4'b0100,
    L_DONE = 4'b1000
  } lstate_t;

  lstate_t     state;
  logic [31:0] m;
  logic [5:0]  msb;
  logic [15:0] frac;
  logic [4:0]  cnt;
  logic [63:0] sq;
  logic [32:0] sq_sh;

  assign sq    = {32'd0, m} * {32'd0, m};
  assign sq_sh = sq[63:31];
  assign done  = (state == L_DONE);
  assign result = {msb - 6'd16, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      case (state)
        L_IDLE: begin
          if (go) begin
            m <= x;
            msb <= 6'd31;
            state <= L_NORM;
          end
        end
        L_NORM: begin
          if (m[31] || msb == 6'd0) begin
            cnt <= 5'd0;
            frac <= 16'd0;
            state <= L_SQR;
          end else begin
            m <= {m[30:0], 1'b0};
            msb <= msb - 6'd1;
          end
        end
        L_SQR: begin
          frac <= {frac[14:0], sq_sh[32]};
          m <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
          cnt <= cnt + 5'd1;
          if (cnt == 5'd15) begin
            state <= L_DONE;
          end
        end
        L_DONE: begin
          if (go) begin
            m <= x;
            msb <= 6'd31;
            state <= L_NORM;
          end else begin
            state <= L_IDLE;
          end
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/hba_divider.sv
module hba_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [33:0] num,
  input  logic [30:0] den,
  output logic        done,
  output logic [33:0] quot,
  output logic        rem_nz
);

  logic        busy;
  logic [5:0]  cnt;
  logic [33:0] q;
  logic [31:0] r;
  logic [32:0] trial;

  assign trial  = {r, q[33]} - {2'b0, den};
  assign quot   = q;
  assign rem_nz = (r != 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        q <= num;
        r <= 32'd0;
        cnt <= 6'd0;
      end else if (busy) begin
        if (trial[32]) begin
          r <= {r[30:0], q[33]};
          q <= {q[32:0], 1'b0};
        end else begin
          r <= trial[31:0];
          q <= {q[32:0], 1'b1};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd33) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/histogram_bin_accumulator_core.sv
// Bins signed Q16.16 samples into saturating 32-bit counters. An add runs the
// 34-step bit-serial divider and then the counter read-modify-write; in log
// mode two 16-step squaring log2 passes, on the sample and then on the lower
// edge, each first normalizing away leading zeros, come before the divider.
// A read, and a non-positive sample in log mode, skip the divider. After
// reset a clearing pass zeroes all MAX_BINS counters with busy high. Each
// result is shown for one cycle with done high; the receiver cannot stall it.
module histogram_bin_accumulator_core #(
  parameter int MAX_BINS = hba_pkg::MAX_BINS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [31:0] sample,
  input  logic [9:0]  read_bin,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [9:0]  bin_index,
  output logic [31:0] bin_count,
  output logic        clamped
);

  localparam int AW = $clog2(MAX_BINS);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_LOGX  = 11'b00000000100,
    S_LOGL  = 11'b00000001000,
    S_DIVGO = 11'b00000010000,
    S_DIV   = 11'b00000100000,
    S_CHECK = 11'b00001000000,
    S_RD    = 11'b00010000000,
    S_WAIT  = 11'b00100000000,
    S_WR    = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t          state;
  hba_pkg::cfg_t   cfg;
  logic [31:0]     mem [MAX_BINS];
  logic [31:0]     rdata;
  logic [AW-1:0]   addr;
  logic [AW:0]     clr;
  logic            is_read;
  logic            rd_valid;
  logic [21:0]     lx;
  logic [33:0]     diff;
  logic [33:0]     dnum;
  logic [30:0]     wden;
  logic            dneg;
  logic            lg_go;
  logic [31:0]     lg_x;
  logic            lg_done;
  logic [21:0]     lg_res;
  logic            dv_go;
  logic            dv_done;
  logic [33:0]     dv_q;
  logic            dv_rnz;
  logic [34:0]     qabs;
  logic [34:0]     qs;
  logic [11:0]     nb;
  logic [31:0]     lo_eff;
  logic [9:0]      idx_r;
  logic            clamp_r;
  logic            wr_en;
  logic [31:0]     wr_data;

  assign cfg_ready = 1'b1;
  assign busy = (state != S_IDLE);
  assign wden = (cfg.bin_width == 31'd0) ? 31'd1 : cfg.bin_width;
  assign nb = (cfg.bins_in_use == 11'd0) ? 12'd1 :
              ({1'b0, cfg.bins_in_use} > 12'(MAX_BINS)) ? 12'(MAX_BINS) :
              {1'b0, cfg.bins_in_use};
  assign lo_eff = ($signed(cfg.range_low) > 0) ? cfg.range_low : 32'd1;
  assign lg_go = (state == S_IDLE && start && op == hba_pkg::OP_ADD &&
                  cfg.log_mode && $signed(sample) > 0) ||
                 (state == S_LOGX && lg_done);
  assign lg_x = (state == S_IDLE) ? sample : lo_eff;
  assign dv_go = (state == S_DIVGO);
  assign dnum = diff[33] ? (~diff + 34'd1) : diff;
  assign qabs = {1'b0, dv_q} + {34'd0, dneg & dv_rnz};
  assign qs = dneg ? (~qabs + 35'd1) : qabs;

  hba_log2 u_log2 (
    .clk(clk), .rst(rst), .go(lg_go), .x(lg_x), .done(lg_done), .result(lg_res)
  );

  hba_divider u_div (
    .clk(clk), .rst(rst), .go(dv_go), .num(dnum), .den(wden),
    .done(dv_done), .quot(dv_q), .rem_nz(dv_rnz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.log_mode <= 1'b0;
      cfg.range_low <= 32'd0;
      cfg.bin_width <= 31'd65536;
      cfg.bins_in_use <= 11'd1024;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hba_pkg::REG_LOG_MODE:    cfg.log_mode <= cfg_data[0];
        hba_pkg::REG_RANGE_LOW:   cfg.range_low <= cfg_data;
        hba_pkg::REG_BIN_WIDTH:   cfg.bin_width <= cfg_data[30:0];
        hba_pkg::REG_BINS_IN_USE: cfg.bins_in_use <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    rdata <= mem[addr];
  end

  always_comb begin
    wr_en = (state == S_CLEAR) || (state == S_WR && rd_valid);
    wr_data = (state == S_CLEAR) ? 32'd0 :
              (rdata == 32'hFFFFFFFF) ? rdata : rdata + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      addr <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          addr <= clr[AW-1:0] + AW'(1);
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(MAX_BINS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            is_read <= op;
            clamp_r <= 1'b0;
            if (op == hba_pkg::OP_READ) begin
              idx_r <= read_bin;
              rd_valid <= ({1'b0, read_bin} < 11'(MAX_BINS));
              addr <= AW'(read_bin);
              state <= S_RD;
            end else if (cfg.log_mode) begin
              if ($signed(sample) <= 0) begin
                idx_r <= 10'd0;
                clamp_r <= 1'b1;
                rd_valid <= 1'b1;
                addr <= '0;
                state <= S_RD;
              end else begin
                state <= S_LOGX;
              end
            end else begin
              diff <= {{2{sample[31]}}, sample} -
                      {{2{cfg.range_low[31]}}, cfg.range_low};
              state <= S_DIVGO;
            end
          end
        end
        S_LOGX: begin
          if (lg_done) begin
            lx <= lg_res;
            state <= S_LOGL;
          end
        end
        S_LOGL: begin
          if (lg_done) begin
            diff <= {{12{lx[21]}}, lx} - {{12{lg_res[21]}}, lg_res};
            state <= S_DIVGO;
          end
        end
        S_DIVGO: begin
          dneg <= diff[33];
          state <= S_DIV;
        end
        S_DIV: begin
          if (dv_done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          rd_valid <= 1'b1;
          if (qs[34]) begin
            idx_r <= 10'd0;
            clamp_r <= 1'b1;
            addr <= '0;
          end else if (qs >= {23'd0, nb}) begin
            idx_r <= 10'(nb - 12'd1);
            clamp_r <= 1'b1;
            addr <= AW'(nb - 12'd1);
          end else begin
            idx_r <= qs[9:0];
            addr <= AW'(qs);
          end
          state <= S_RD;
        end
        S_RD: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          state <= is_read ? S_OUT : S_WR;
          if (is_read) begin
            bin_count <= rd_valid ? rdata : 32'd0;
          end
        end
        S_WR: begin
          bin_count <= wr_data;
          state <= S_OUT;
        end
        S_OUT: begin
          done <= 1'b1;
          bin_index <= idx_r;
          clamped <= clamp_r;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### bench/hba_checker.sv
module hba_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        op,
  input  logic [31:0] sample,
  input  logic [9:0]  read_bin,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        done,
  input  logic [9:0]  bin_index,
  input  logic [31:0] bin_count,
  input  logic        clamped,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [9:0]  idx;
    logic [31:0] cnt;
    logic        clamp;
  } bin_word_t;

  logic        mode_log;
  logic [31:0] lo_edge;
  logic [30:0] width;
  logic [10:0] nbins;
  logic [31:0] counts [hba_pkg::MAX_BINS_DEF];
  bin_word_t   expected_words [$];

  assign pending = expected_words.size();

  function automatic longint fixed_log2(logic [31:0] x);
    int msb;
    logic [63:0] m;
    longint frac;
    msb = 31;
    frac = 0;
    while (msb > 0 && x[msb] == 1'b0) msb--;
    m = 64'(x) << (31 - msb);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(msb - 16) * 65536 + frac;
  endfunction

  function automatic longint div_floor(longint num, longint den);
    longint q;
    q = num / den;
    if (num < 0 && q * den != num) q = q - 1;
    return q;
  endfunction

  function automatic bin_word_t bin_sample(logic is_read, logic [31:0] s, logic [9:0] rb);
    bin_word_t r;
    longint n, w, q, lo, sv;
    r = '0;
    if (is_read == hba_pkg::OP_READ) begin
      r.idx = rb;
      r.cnt = counts[rb];
      return r;
    end
    n = longint'(nbins);
    if (n < 1) n = 1;
    if (n > hba_pkg::MAX_BINS_DEF) n = hba_pkg::MAX_BINS_DEF;
    w = (width == 0) ? 1 : longint'(width);
    sv = longint'($signed(s));
    lo = longint'($signed(lo_edge));
    if (mode_log) begin
      if (sv <= 0) q = -1;
      else begin
        if (lo <= 0) lo = 1;
        q = div_floor(fixed_log2(s) - fixed_log2(32'(lo)), w);
      end
    end else q = div_floor(sv - lo, w);
    if (q < 0) begin
      q = 0;
      r.clamp = 1'b1;
    end else if (q >= n) begin
      q = n - 1;
      r.clamp = 1'b1;
    end
    r.idx = 10'(q);
    if (counts[r.idx] != 32'hFFFF_FFFF) counts[r.idx] = counts[r.idx] + 1;
    r.cnt = counts[r.idx];
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    bin_word_t e;
    if (rst) begin
      fail_count = 0;
      mode_log <= 1'b0;
      lo_edge <= '0;
      width <= 31'd65536;
      nbins <= 11'd1024;
      for (int i = 0; i < hba_pkg::MAX_BINS_DEF; i++) counts[i] = '0;
      expected_words.delete();
    end else begin
      if (done) begin
        if (expected_words.size() == 0) report("unexpected word", 32'(bin_index), 32'd0);
        else begin
          e = expected_words.pop_front();
          if (bin_index !== e.idx) report("bin_index", 32'(bin_index), 32'(e.idx));
          if (bin_count !== e.cnt) report("bin_count", bin_count, e.cnt);
          if (clamped !== e.clamp) report("clamped", 32'(clamped), 32'(e.clamp));
        end
      end
      if (start && !busy) begin
        expected_words.insert(expected_words.size(), bin_sample(op, sample, read_bin));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hba_pkg::REG_LOG_MODE: mode_log <= cfg_data[0];
          hba_pkg::REG_RANGE_LOW: lo_edge <= cfg_data;
          hba_pkg::REG_BIN_WIDTH: width <= cfg_data[30:0];
          hba_pkg::REG_BINS_IN_USE: nbins <= cfg_data[10:0];
          default: ;
        endcase
      end
    end
  end
endmodule

### bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        op = hba_pkg::OP_ADD;
  logic [31:0] sample = '0;
  logic [9:0]  read_bin = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = hba_pkg::REG_LOG_MODE;
  logic [31:0] cfg_data = '0;
  logic        done;
  logic [9:0]  bin_index;
  logic [31:0] bin_count;
  logic        clamped;
  int          fail_count;
  int          pending;
  int          idle_pct = 0;
  longint      cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  histogram_bin_accumulator_core u_dut (.*);

  hba_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2_000_000) begin
      $display("FAIL histogram_bin_accumulator_core");
      $finish;
    end
  end

  task automatic send(logic o, logic [31:0] s, logic [9:0] rb);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1'b1;
    op <= o;
    sample <= s;
    read_bin <= rb;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] i, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= i;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(logic m, logic [31:0] lo, logic [31:0] w, logic [31:0] n);
    drain();
    write_reg(hba_pkg::REG_LOG_MODE, {31'd0, m});
    write_reg(hba_pkg::REG_RANGE_LOW, lo);
    write_reg(hba_pkg::REG_BIN_WIDTH, w);
    write_reg(hba_pkg::REG_BINS_IN_USE, n);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< $urandom_range(16);
      2: return $urandom_range(32'h7FFF_FFFF, 1);
      default: return $urandom_range(32'h0040_0000);
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) idle_pct = ($urandom_range(3) == 0) ? 0 : ($urandom_range(1) ? 60 : 26);
      if ($urandom_range(4) == 0) send(hba_pkg::OP_READ, $urandom, 10'($urandom));
      else send(hba_pkg::OP_ADD, rand_sample(), 10'($urandom));
    end
    idle_pct = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // directed words at reset settings
    send(hba_pkg::OP_ADD, 32'h0000_0000, '0);
    send(hba_pkg::OP_ADD, 32'h8000_0000, '0);
    send(hba_pkg::OP_ADD, 32'h7FFF_FFFF, '0);
    send(hba_pkg::OP_ADD, 32'hFFFF_FFFF, '0);
    send(hba_pkg::OP_ADD, 32'h0003_8000, 10'h3FF);
    send(hba_pkg::OP_READ, '0, 10'd0);
    send(hba_pkg::OP_READ, '0, 10'd1023);
    send(hba_pkg::OP_READ, 32'hFFFF_FFFF, 10'd3);
    setup(1'b0, 32'hFFFF_0000, 32'd0, 32'd0);
    send(hba_pkg::OP_ADD, 32'h1234_5678, '0);
    send(hba_pkg::OP_ADD, 32'h8000_0000, '0);
    setup(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd2047);
    send(hba_pkg::OP_ADD, 32'h7FFF_FFFF, '0);
    send(hba_pkg::OP_ADD, 32'h8000_0000, '0);
    setup(1'b1, 32'h0001_0000, 32'h0000_4000, 32'd64);
    send(hba_pkg::OP_ADD, 32'h0000_0000, '0);
    send(hba_pkg::OP_ADD, 32'hFFFF_0000, '0);
    send(hba_pkg::OP_ADD, 32'h0000_0001, '0);
    send(hba_pkg::OP_ADD, 32'h7FFF_FFFF, '0);
    send(hba_pkg::OP_ADD, 32'h0002_0000, '0);
    setup(1'b1, 32'h8000_0000, 32'h0001_0000, 32'd1024);
    send(hba_pkg::OP_ADD, 32'h0000_0001, '0);
    send(hba_pkg::OP_ADD, 32'h0001_0000, '0);
    send(hba_pkg::OP_READ, '0, 10'd16);
    random_phase(250);
    setup(1'b0, $urandom, $urandom_range(32'h0010_0000, 1), $urandom_range(1024, 1));
    random_phase(250);
    setup(1'b0, 32'hFFF0_0000, 32'h0000_0100, 32'd8);
    random_phase(200);
    setup(1'b1, 32'h0000_0100, 32'h0000_8000, 32'd40);
    random_phase(150);
    setup(1'b1, $urandom_range(32'h0100_0000, 1), $urandom_range(32'h0002_0000, 1),
          $urandom_range(2047));
    random_phase(150);
    setup(1'b0, 32'h0000_0000, 32'h0000_0001, 32'd1);
    random_phase(100);
    setup(1'b0, $urandom, $urandom, $urandom);
    random_phase(200);
    drain();
    if (fail_count == 0) $display("PASS histogram_bin_accumulator_core");
    else $display("FAIL histogram_bin_accumulator_core");
    $finish;
  end
endmodule
